### rtl/breakpoint_match_table_assert.svh
// Assertion macros for the breakpoint match table.
// Expects clk and arst_n in the scope that uses them.
`ifndef BREAKPOINT_MATCH_TABLE_ASSERT_SVH
`define BREAKPOINT_MATCH_TABLE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define BMT_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define BMT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/bmt_pkg.sv
// Shared types and constants of the breakpoint match table.
// No dependencies; imported by the interfaces, the cell and the top level.
`timescale 1ns / 1ps
`default_nettype none

package bmt_pkg;

	localparam int unsigned BMT_ENTRIES  = 16;
	localparam int unsigned BMT_ID_WIDTH = 16;

	localparam int unsigned TYPE_W = 3;
	localparam int unsigned ADDR_W = 32;
	localparam int unsigned TID_W  = 16;
	localparam int unsigned RID_W  = 16;
	localparam int unsigned STAT_W = 2;

	// Request codes; 6 and 7 are undefined and ignored.
	typedef enum logic [TYPE_W-1:0] {
		OP_ADD    = 3'd0,
		OP_DEL    = 3'd1,
		OP_CHECK  = 3'd2,
		OP_FIND   = 3'd3,
		OP_SKIP   = 3'd4,
		OP_UNSKIP = 3'd5
	} op_t;

	localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
	localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;

	// Scan token flags handed from cell to cell.
	typedef struct packed {
		logic active;
		logic found;
		logic en;
		logic free;
	} scan_flags_t;

	// Commit command broadcast to all cells at the end of a scan.
	typedef struct packed {
		logic add;
		logic del;
		logic set_en;
		logic en_val;
		logic all_en;
	} commit_t;

endpackage

`default_nettype wire

### rtl/bmt_ifs.sv
// Request and response channels of the breakpoint match table.
// Depends on bmt_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface bmt_req_if import bmt_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [TYPE_W-1:0] req_type;
	logic [ADDR_W-1:0] address;
	logic [TID_W-1:0]  target_id;

	modport source (output valid, req_type, address, target_id, input ready);
	modport sink   (input valid, req_type, address, target_id, output ready);
endinterface

interface bmt_rsp_if import bmt_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              hit;
	logic [RID_W-1:0]  result_id;
	logic [STAT_W-1:0] status;

	modport source (output valid, hit, result_id, status, input ready);
	modport sink   (input valid, hit, result_id, status, output ready);
endinterface

`default_nettype wire

### rtl/bmt_cell.sv
// One breakpoint slot plus its stage of the scan chain.
// Depends on bmt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bmt_cell import bmt_pkg::*; #(
	parameter int unsigned ENTRIES  = BMT_ENTRIES,
	parameter int unsigned ID_WIDTH = BMT_ID_WIDTH,
	parameter int unsigned INDEX    = 0,
	localparam int unsigned IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
	input  wire                     clk,
	input  wire                     arst_n,
	// request under scan, held stable by the top level
	input  wire [TYPE_W-1:0]        req_op,
	input  wire [ADDR_W-1:0]        req_addr,
	input  wire [TID_W-1:0]         req_tid,
	input  wire [ID_WIDTH-1:0]      next_id,
	// scan token from the left neighbor
	input  scan_flags_t             flg_in,
	input  wire [IDX_W-1:0]         idx_in,
	input  wire [ID_WIDTH-1:0]      id_in,
	input  wire [IDX_W-1:0]         free_idx_in,
	// scan token to the right neighbor
	output scan_flags_t             flg_out,
	output logic [IDX_W-1:0]        idx_out,
	output logic [ID_WIDTH-1:0]     id_out,
	output logic [IDX_W-1:0]        free_idx_out,
	// commit
	input  commit_t                 cmd,
	input  wire [IDX_W-1:0]         cmd_idx
);

	localparam int unsigned CMP_W = (ID_WIDTH > TID_W) ? ID_WIDTH : TID_W;
	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

	logic                valid_q;
	logic [ADDR_W-1:0]   addr_q;
	logic [ID_WIDTH-1:0] id_q;
	logic                en_q;

	logic        addr_hit, id_hit, take, mine;
	scan_flags_t flg_nxt;

	assign addr_hit = valid_q && (addr_q == req_addr);
	// target id zero never matches; ids wider than ID_WIDTH never match
	assign id_hit = valid_q && (req_tid != '0) &&
		(CMP_W'(id_q) == CMP_W'(req_tid));

	always_comb begin
		if (req_op == OP_DEL)
			take = id_hit && !flg_in.found;
		else
			take = addr_hit && (!flg_in.found || (id_q > id_in));
		flg_nxt.active = flg_in.active;
		flg_nxt.found  = flg_in.found | take;
		flg_nxt.en     = take ? en_q : flg_in.en;
		flg_nxt.free   = flg_in.free | !valid_q;
	end

	// flags other than active hold once the token has passed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flg_out <= '0;
		end else if (flg_in.active) begin
			flg_out <= flg_nxt;
		end else begin
			flg_out.active <= 1'b0;
		end
	end

	// token payload holds once the token has passed
	always_ff @(posedge clk) begin
		if (flg_in.active) begin
			idx_out      <= take ? MY_IDX : idx_in;
			id_out       <= take ? id_q : id_in;
			free_idx_out <= (!flg_in.free && !valid_q) ? MY_IDX : free_idx_in;
		end
	end

	assign mine = (cmd_idx == MY_IDX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			if (cmd.add && mine)
				valid_q <= 1'b1;
			else if (cmd.del && mine)
				valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.add && mine) begin
			addr_q <= req_addr;
			id_q   <= next_id;
			en_q   <= 1'b1;
		end else if (cmd.set_en && mine) begin
			en_q <= cmd.en_val;
		end else if (cmd.all_en && valid_q) begin
			en_q <= 1'b1;
		end
	end

endmodule

`default_nettype wire

### rtl/breakpoint_match_table.sv
// Breakpoint match table top level: request sequencer, cell chain, response register.
// Depends on bmt_pkg, bmt_ifs, bmt_cell and breakpoint_match_table_assert.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "breakpoint_match_table_assert.svh"

//  channel | dir | beat fields
//  --------+-----+-------------------------------------
//  req     | in  | req_type, address, target_id
//  rsp     | out | hit, result_id, status
//
// Response path: the accept edge loads the launch pulse, the token then walks
// through the cell chain (one cell per cycle), the token at the tail moves the
// sequencer into the finish state, and the commit edge loads the response.
// One request is in flight at a time; req.ready is high only when idle, so
// the next request is accepted only after the previous one has committed.
// A finished response waits in the finish state while rsp is stalled; the
// table update commits in the same cycle the response register loads.
// arst_n clears the valid bits, the id counter (to 1) and the handshakes.

module breakpoint_match_table import bmt_pkg::*; #(
	parameter int unsigned ENTRIES  = BMT_ENTRIES,
	parameter int unsigned ID_WIDTH = BMT_ID_WIDTH
) (
	input wire       clk,
	input wire       arst_n,
	bmt_req_if.sink   req,
	bmt_rsp_if.source rsp
);

	localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FIN} state_t;

	state_t              state_q;
	logic                launch_q;
	logic [TYPE_W-1:0]   op_q;
	logic [ADDR_W-1:0]   addr_q;
	logic [TID_W-1:0]    tid_q;
	logic [ID_WIDTH-1:0] next_q;
	logic                rsp_valid_q;
	logic                hit_q;
	logic [RID_W-1:0]    rid_q;
	logic [STAT_W-1:0]   stat_q;

	// scan chain taps; element 0 is the launch point, ENTRIES the tail
	scan_flags_t         flg_c      [0:ENTRIES];
	logic [IDX_W-1:0]    idx_c      [0:ENTRIES];
	logic [ID_WIDTH-1:0] id_c       [0:ENTRIES];
	logic [IDX_W-1:0]    free_idx_c [0:ENTRIES];

	commit_t          cmd, cmd_out;
	logic [IDX_W-1:0] cmd_idx;
	logic             r_hit;
	logic [RID_W-1:0] r_id;
	logic [STAT_W-1:0] r_st;
	logic             fire;
	scan_flags_t      tail;

	always_comb begin
		flg_c[0]        = '0;
		flg_c[0].active = launch_q;
	end
	assign idx_c[0]      = '0;
	assign id_c[0]       = '0;
	assign free_idx_c[0] = '0;

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		bmt_cell #(
			.ENTRIES  (ENTRIES),
			.ID_WIDTH (ID_WIDTH),
			.INDEX    (i)
		) u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.req_op       (op_q),
			.req_addr     (addr_q),
			.req_tid      (tid_q),
			.next_id      (next_q),
			.flg_in       (flg_c[i]),
			.idx_in       (idx_c[i]),
			.id_in        (id_c[i]),
			.free_idx_in  (free_idx_c[i]),
			.flg_out      (flg_c[i+1]),
			.idx_out      (idx_c[i+1]),
			.id_out       (id_c[i+1]),
			.free_idx_out (free_idx_c[i+1]),
			.cmd          (cmd_out),
			.cmd_idx      (cmd_idx)
		);
	end

	assign tail = flg_c[ENTRIES];
	// commit and load the response only when the output register is empty or its beat is being taken
	assign fire = (state_q == S_FIN) && (!rsp_valid_q || rsp.ready);

	// Decide result and table update from the token at the tail.
	always_comb begin
		cmd     = '0;
		cmd_idx = idx_c[ENTRIES];
		r_hit   = 1'b0;
		r_id    = '0;
		r_st    = ST_OK;
		case (op_q)
			OP_ADD: begin
				if (!tail.free || (next_q == '0)) begin
					r_st = ST_FULL;
				end else begin
					cmd.add = 1'b1;
					cmd_idx = free_idx_c[ENTRIES];
					r_id    = RID_W'(next_q);
				end
			end
			OP_DEL: begin
				if (tail.found)
					cmd.del = 1'b1;
				else
					r_st = ST_NOT_FOUND;
			end
			OP_CHECK: begin
				if (!tail.found) begin
					r_st = ST_NOT_FOUND;
				end else if (tail.en) begin
					r_hit = 1'b1;
				end else begin
					// disabled match: re-arm, no hit
					cmd.set_en = 1'b1;
					cmd.en_val = 1'b1;
				end
			end
			OP_FIND: begin
				if (tail.found)
					r_id = RID_W'(id_c[ENTRIES]);
				else
					r_st = ST_NOT_FOUND;
			end
			OP_SKIP: begin
				if (tail.found) begin
					cmd.set_en = 1'b1;
					cmd.en_val = 1'b0;
				end else begin
					r_st = ST_NOT_FOUND;
				end
			end
			OP_UNSKIP: cmd.all_en = 1'b1;
			default: ;
		endcase
	end

	assign cmd_out = fire ? cmd : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			launch_q    <= 1'b0;
			op_q        <= '0;
			addr_q      <= '0;
			tid_q       <= '0;
			next_q      <= ID_WIDTH'(1);
			rsp_valid_q <= 1'b0;
			hit_q       <= 1'b0;
			rid_q       <= '0;
			stat_q      <= ST_OK;
		end else begin
			// one-cycle pulse on the accepting edge
			launch_q <= (state_q == S_IDLE) && req.valid;
			if (fire)
				rsp_valid_q <= 1'b1;
			else if (rsp.ready)
				rsp_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						op_q    <= req.req_type;
						addr_q  <= req.address;
						tid_q   <= req.target_id;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (tail.active)
						state_q <= S_FIN;
				end
				S_FIN: begin
					if (fire) begin
						hit_q  <= r_hit;
						rid_q  <= r_id;
						stat_q <= r_st;
						if (cmd.add)
							next_q <= next_q + ID_WIDTH'(1); // wraps to 0, then adds fail
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign req.ready     = (state_q == S_IDLE);
	assign rsp.valid     = rsp_valid_q;
	assign rsp.hit       = hit_q;
	assign rsp.result_id = rid_q;
	assign rsp.status    = stat_q;

	// Accepted beat launches exactly one scan token.
	`BMT_ASSERT_NEXT(a_launch, req.valid && req.ready, (state_q == S_SCAN) && launch_q, "accept did not launch scan")
	// Token only reaches the tail while a scan is running.
	`BMT_ASSERT_NOW(a_tail_scan, tail.active, state_q == S_SCAN, "scan token at tail outside scan")
	// A commit always produces a response beat.
	`BMT_ASSERT_NEXT(a_fire_rsp, fire, rsp_valid_q && (state_q == S_IDLE), "commit without response")
	// A full table never reports an id or a hit.
	`BMT_ASSERT_NOW(a_full_clean, rsp_valid_q && (stat_q == ST_FULL), (rid_q == '0) && !hit_q, "full status with payload")

endmodule

`default_nettype wire

### verif/breakpoint_table_checker.sv
// Result checker for the breakpoint match table: watches the req and rsp channels,
// predicts every response and compares it. Depends on bmt_pkg and bmt_ifs.
`timescale 1ns / 1ps

module breakpoint_table_checker import bmt_pkg::*; #(
	parameter int unsigned ENTRIES  = BMT_ENTRIES,
	parameter int unsigned ID_WIDTH = BMT_ID_WIDTH
) (
	input wire  clk,
	input wire  arst_n,
	bmt_req_if  req,
	bmt_rsp_if  rsp,
	output int  fail_count,
	output int  outstanding
);

	typedef struct packed {
		logic              hit;
		logic [RID_W-1:0]  rid;
		logic [STAT_W-1:0] status;
	} bp_result_t;

	localparam longint unsigned ID_MASK = (64'd1 << ID_WIDTH) - 64'd1;

	// Shadow table
	logic              slot_live [ENTRIES];
	logic [ADDR_W-1:0] slot_addr [ENTRIES];
	longint unsigned   slot_id   [ENTRIES];
	logic              slot_on   [ENTRIES];
	longint unsigned   id_next;

	bp_result_t due_results[$];
	int         fails;

	// Newest (highest id) live slot at addr, -1 if none.
	function automatic int newest_at(logic [ADDR_W-1:0] addr);
		int best;
		best = -1;
		for (int i = 0; i < ENTRIES; i++) begin
			if (slot_live[i] && slot_addr[i] == addr && (best < 0 || slot_id[i] > slot_id[best]))
				best = i;
		end
		return best;
	endfunction

	// Applies one request beat to the shadow table, returns the response it owes.
	function automatic bp_result_t apply_request(logic [TYPE_W-1:0] code,
			logic [ADDR_W-1:0] addr, logic [TID_W-1:0] tid);
		bp_result_t r;
		int         k;
		r = '0;
		k = -1;
		case (code)
			OP_ADD: begin
				for (int i = 0; i < ENTRIES; i++)
					if (!slot_live[i] && k < 0)
						k = i;
				if (k < 0 || id_next == 0) begin
					r.status = ST_FULL;
				end else begin
					slot_live[k] = 1'b1;
					slot_addr[k] = addr;
					slot_id[k]   = id_next;
					slot_on[k]   = 1'b1;
					r.rid        = RID_W'(id_next);
					id_next      = (id_next + 1) & ID_MASK;
				end
			end
			OP_DEL: begin
				r.status = ST_NOT_FOUND;
				if (tid != 0) begin
					for (int i = 0; i < ENTRIES; i++) begin
						if (r.status == ST_NOT_FOUND && slot_live[i] && slot_id[i] == tid) begin
							slot_live[i] = 1'b0;
							r.status     = ST_OK;
						end
					end
				end
			end
			OP_CHECK: begin
				k = newest_at(addr);
				if (k < 0)
					r.status = ST_NOT_FOUND;
				else if (slot_on[k])
					r.hit = 1'b1;
				else
					slot_on[k] = 1'b1;
			end
			OP_FIND: begin
				k = newest_at(addr);
				if (k < 0)
					r.status = ST_NOT_FOUND;
				else
					r.rid = RID_W'(slot_id[k]);
			end
			OP_SKIP: begin
				k = newest_at(addr);
				if (k < 0)
					r.status = ST_NOT_FOUND;
				else
					slot_on[k] = 1'b0;
			end
			OP_UNSKIP: begin
				for (int i = 0; i < ENTRIES; i++)
					if (slot_live[i])
						slot_on[i] = 1'b1;
			end
			default: ;
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : track
		bp_result_t got;
		bp_result_t want;
		string      want_s;
		if (!arst_n) begin
			for (int i = 0; i < ENTRIES; i++)
				slot_live[i] = 1'b0;
			id_next = 1;
			due_results.delete();
			fails = 0;
		end else begin
			// Compare first: a response in the same cycle belongs to an older request.
			if (rsp.valid && rsp.ready) begin
				got.hit    = rsp.hit;
				got.rid    = rsp.result_id;
				got.status = rsp.status;
				if (due_results.size() == 0) begin
					fails++;
					if (fails <= 10)
						$display("[%0t] unexpected result beat: hit=%0b id=%0d status=%0d",
							$time, got.hit, got.rid, got.status);
				end else begin
					want = due_results.pop_front();
					if (got.hit !== want.hit || got.rid !== want.rid || got.status !== want.status) begin
						fails++;
						if (fails <= 10) begin
							want_s = $sformatf("hit=%0b id=%0d status=%0d", want.hit, want.rid,
								want.status);
							$display("[%0t] result mismatch: expected %s, got hit=%0b id=%0d status=%0d",
								$time, want_s, got.hit, got.rid, got.status);
						end
					end
				end
			end
			if (req.valid && req.ready)
				due_results.push_back(apply_request(req.req_type, req.address, req.target_id));
		end
		fail_count  <= fails;
		outstanding <= due_results.size();
	end

endmodule

### verif/tb_breakpoint_match_table.sv
// Testbench top for the breakpoint match table: clock, reset, request stimulus,
// response pacing and verdict. Depends on bmt_pkg, bmt_ifs and breakpoint_table_checker.
`timescale 1ns / 1ps

module tb_breakpoint_match_table;
	import bmt_pkg::*;

	localparam int unsigned TB_ENTRIES      = BMT_ENTRIES;
	// Narrow id counter so that running it out fits in a short run.
	localparam int unsigned TB_ID_WIDTH     = 8;
	localparam int unsigned RANDOM_BEATS    = 1100;
	localparam int unsigned CYCLE_LIMIT     = 1_000_000;
	localparam int unsigned HOLD_OFF_CYCLES = 400;
	// Wait at the end, sized from the entry count plus slack.
	localparam int unsigned DRAIN_CYCLES    = TB_ENTRIES + 8;

	// Undefined request codes, ignored by the block.
	localparam logic [TYPE_W-1:0] OP_RSVD6 = 3'd6;
	localparam logic [TYPE_W-1:0] OP_RSVD7 = 3'd7;

	// Entry that survives the id exhaustion sweep.
	localparam logic [ADDR_W-1:0] KEEPER_ADDR = 32'h0000_1000;

	logic clk;
	logic arst_n;

	bmt_req_if req();
	bmt_rsp_if rsp();

	int fail_count;
	int outstanding;

	// Pacing knobs, percent of cycles
	int idle_pct  = 0;
	int stall_pct = 0;
	// Receiver hold-off request, counted down by the pacing process
	int hold_len  = 0;

	int unsigned beats_accepted = 0;
	int unsigned beats_returned = 0;
	int unsigned cycle_count    = 0;

	logic [RID_W-1:0]  last_rid;
	logic [STAT_W-1:0] last_status;
	logic [ADDR_W-1:0] recent_addr = 32'hdead_beef;

	// Ids seen on the response side; deletes mostly target these.
	int unsigned id_pool[$];

	breakpoint_match_table #(
		.ENTRIES (TB_ENTRIES),
		.ID_WIDTH(TB_ID_WIDTH)
	) uut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.rsp   (rsp)
	);

	breakpoint_table_checker #(
		.ENTRIES (TB_ENTRIES),
		.ID_WIDTH(TB_ID_WIDTH)
	) bp_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.rsp        (rsp),
		.fail_count (fail_count),
		.outstanding(outstanding)
	);

	// 12 ns clock
	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Hard stop
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("breakpoint_match_table verification failed");
			$finish;
		end
	end

	// Response side pacing. A pending hold-off wins over random stalls and
	// keeps ready low until it has counted down, while the sender keeps offering.
	initial begin : rsp_pacing
		rsp.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_len > 0) begin
				hold_len = hold_len - 1;
				rsp.ready <= 1'b0;
			end else begin
				rsp.ready <= ($urandom_range(0, 99) >= stall_pct);
			end
		end
	end

	// Response watcher: counts beats and harvests live ids for later deletes.
	always @(posedge clk) begin : rsp_watch
		bit dup;
		if (arst_n && rsp.valid && rsp.ready) begin
			beats_returned = beats_returned + 1;
			last_rid       = rsp.result_id;
			last_status    = rsp.status;
			if (rsp.result_id != 0) begin
				dup = 1'b0;
				foreach (id_pool[i])
					if (id_pool[i] == rsp.result_id)
						dup = 1'b1;
				if (!dup)
					id_pool.push_back(rsp.result_id);
			end
		end
	end

	// Mostly a handful of hot addresses so that lookups match and duplicates
	// pile up; the rest reuses or draws a full 32-bit address.
	function automatic logic [ADDR_W-1:0] pick_addr();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 70) begin
			case ($urandom_range(0, 7))
				0: return 32'h0000_0000;
				1: return 32'hffff_ffff;
				2: return KEEPER_ADDR;
				3: return 32'h0000_1004;
				4: return 32'h8000_0000;
				5: return 32'h7fff_fffc;
				6: return 32'h0040_0000;
				default: return 32'h0040_0004;
			endcase
		end
		if (roll < 85)
			return recent_addr;
		recent_addr = $urandom;
		return recent_addr;
	endfunction

	// Delete target: mostly a known id (taken out of the pool), else id 0,
	// all ones or anything in the field range.
	function automatic logic [TID_W-1:0] pick_tid();
		int unsigned roll;
		int unsigned idx;
		logic [TID_W-1:0] tid;
		roll = $urandom_range(0, 99);
		if (roll < 65 && id_pool.size() != 0) begin
			idx = $urandom_range(0, id_pool.size() - 1);
			tid = TID_W'(id_pool[idx]);
			id_pool.delete(idx);
			return tid;
		end
		if (roll < 75)
			return '0;
		if (roll < 85)
			return '1;
		return TID_W'($urandom_range(0, 65535));
	endfunction

	// One request beat: optional idle cycles, then hold valid until accepted.
	task automatic send_req(input logic [TYPE_W-1:0] code, input logic [ADDR_W-1:0] addr,
			input logic [TID_W-1:0] tid);
		while ($urandom_range(0, 99) < idle_pct) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid     <= 1'b1;
		req.req_type  <= code;
		req.address   <= addr;
		req.target_id <= tid;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
		beats_accepted = beats_accepted + 1;
	endtask

	// Random mix; counted is low for the undefined codes.
	task automatic send_random(output bit counted);
		int unsigned roll;
		roll    = $urandom_range(0, 99);
		counted = 1'b1;
		if (roll < 26)
			send_req(OP_ADD, pick_addr(), TID_W'($urandom));
		else if (roll < 44)
			send_req(OP_DEL, ADDR_W'($urandom), pick_tid());
		else if (roll < 68)
			send_req(OP_CHECK, pick_addr(), TID_W'($urandom));
		else if (roll < 80)
			send_req(OP_FIND, pick_addr(), TID_W'($urandom));
		else if (roll < 91)
			send_req(OP_SKIP, pick_addr(), TID_W'($urandom));
		else if (roll < 96)
			send_req(OP_UNSKIP, ADDR_W'($urandom), TID_W'($urandom));
		else begin
			send_req(($urandom_range(0, 1) != 0) ? OP_RSVD7 : OP_RSVD6, ADDR_W'($urandom),
				TID_W'($urandom));
			counted = 1'b0;
		end
	endtask

	// Wait until every accepted beat has its response back.
	task automatic wait_drained();
		while (beats_returned != beats_accepted)
			@(posedge clk);
	endtask

	initial begin : stimulus
		int unsigned sent;
		bit          counted;
		arst_n        <= 1'b0;
		req.valid     <= 1'b0;
		req.req_type  <= OP_ADD;
		req.address   <= '0;
		req.target_id <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty table, ids, newest-match rule, skip/re-enable, unskip,
		// undefined codes. No idling here.
		send_req(OP_CHECK,  32'h0000_0000, '0);       // nothing there
		send_req(OP_FIND,   32'hffff_ffff, '0);
		send_req(OP_SKIP,   KEEPER_ADDR,   '0);
		send_req(OP_DEL,    '0,            '0);       // id 0 never matches
		send_req(OP_DEL,    '0,            16'hffff); // beyond the id width
		send_req(OP_UNSKIP, '0,            '0);       // empty table, still ok
		send_req(OP_ADD,    32'h0000_0000, 16'hffff); // id 1
		send_req(OP_ADD,    32'hffff_ffff, '0);       // id 2
		send_req(OP_ADD,    32'h0000_0000, '0);       // id 3, same address as id 1
		send_req(OP_FIND,   32'h0000_0000, '0);       // newest wins: 3
		send_req(OP_CHECK,  32'h0000_0000, '0);       // hit
		send_req(OP_SKIP,   32'h0000_0000, '0);       // disables id 3 only
		send_req(OP_CHECK,  32'h0000_0000, '0);       // no hit, re-enabled
		send_req(OP_CHECK,  32'h0000_0000, '0);       // hit again
		send_req(OP_SKIP,   32'hffff_ffff, '0);
		send_req(OP_UNSKIP, 32'hffff_ffff, '0);
		send_req(OP_CHECK,  32'hffff_ffff, '0);       // hit after unskip
		send_req(OP_DEL,    '0,            16'd3);
		send_req(OP_DEL,    '0,            16'd3);    // already gone
		send_req(OP_FIND,   32'h0000_0000, '0);       // falls back to id 1
		send_req(OP_RSVD6,  32'hffff_ffff, 16'hffff);
		send_req(OP_RSVD7,  32'h0000_0000, '0);

		// Random part in four pacing phases. Phase 0 also opens with a long
		// receiver hold-off so the block backs up into the request side.
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					idle_pct  = 0;
					stall_pct = 0;
					hold_len  = HOLD_OFF_CYCLES;
				end
				1: begin
					idle_pct  = 50;
					stall_pct = 0;
				end
				2: begin
					idle_pct  = 0;
					stall_pct = 50;
				end
				default: begin
					idle_pct  = 8;
					stall_pct = 8;
				end
			endcase
			sent = 0;
			while (sent < RANDOM_BEATS / 4) begin
				send_random(counted);
				if (counted)
					sent++;
			end
		end

		// Id exhaustion: empty the table, plant one keeper, then add/delete
		// pairs until an add comes back full with free slots left.
		wait_drained();
		while (id_pool.size() != 0)
			send_req(OP_DEL, ADDR_W'($urandom), TID_W'(id_pool.pop_front()));
		send_req(OP_ADD, KEEPER_ADDR, '0);
		for (int n = 0; n < (1 << TB_ID_WIDTH) + 4; n++) begin
			send_req(OP_ADD, pick_addr(), TID_W'($urandom));
			wait_drained();
			if (last_status == ST_FULL)
				break;
			send_req(OP_DEL, ADDR_W'($urandom), last_rid);
		end

		// Counter stays at zero: adds keep failing, the keeper still works.
		send_req(OP_ADD,    KEEPER_ADDR, '0);
		send_req(OP_ADD,    32'h0000_0000, '0);
		send_req(OP_CHECK,  KEEPER_ADDR, '0);
		send_req(OP_SKIP,   KEEPER_ADDR, '0);
		send_req(OP_CHECK,  KEEPER_ADDR, '0);
		send_req(OP_SKIP,   KEEPER_ADDR, '0);
		send_req(OP_UNSKIP, '0,          '0);
		send_req(OP_FIND,   KEEPER_ADDR, '0);
		sent = 0;
		while (sent < 30) begin
			send_random(counted);
			if (counted)
				sent++;
		end
		req.valid <= 1'b0;

		// Let the checker see the last beat before trusting its count.
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0)
			$display("breakpoint_match_table verification clean");
		else
			$display("breakpoint_match_table verification failed");
		$finish;
	end

endmodule
